// ----- design/assert_macros.svh -----
// Assertion macros used by the deque top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- design/deq_pkg.sv -----
// Types and constants shared by the deque modules
`timescale 1ns / 1ps

package deq_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_PUSH_BACK  = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_BACK   = 2'd3
	} deq_mode_t;

	typedef struct packed {
		logic is_empty;
		logic is_full;
		logic ignored;
	} deq_flags_t;

endpackage

// ----- design/deq_ram.sv -----
// Ring storage: one write port, one registered read port
`timescale 1ns / 1ps

module deq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/deq_ctrl.sv -----
// Head, count and end-value tracking with ring read and write control
`timescale 1ns / 1ps

module deq_ctrl #(
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       mode,
	input  logic signed [deq_pkg::DATA_W-1:0] value,
	output logic                             done,
	output logic signed [deq_pkg::DATA_W-1:0] front_value,
	output logic signed [deq_pkg::DATA_W-1:0] back_value,
	output logic [deq_pkg::COUNT_W-1:0]      entry_count,
	output deq_pkg::deq_flags_t              flags,
	output logic                             ram_we,
	output logic [AW-1:0]                    ram_waddr,
	output logic [deq_pkg::DATA_W-1:0]       ram_wdata,
	output logic                             ram_re,
	output logic [AW-1:0]                    ram_raddr,
	input  logic [deq_pkg::DATA_W-1:0]       ram_rdata
);

	import deq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [AW-1:0]             head_q;
	logic [CW-1:0]             count_q;
	logic signed [DATA_W-1:0]  front_q;
	logic signed [DATA_W-1:0]  back_q;
	logic                      valid_s1;
	logic                      rd_front_s1;
	logic                      rd_back_s1;
	logic                      ignored_s1;

	logic                      accept;
	logic                      empty;
	logic                      full;
	logic                      many;
	logic [AW-1:0]             head_inc;
	logic [AW-1:0]             head_dec;
	logic [SW-1:0]             tail_sum;
	logic [SW-1:0]             back_sum;
	logic [AW-1:0]             tail_idx;
	logic [AW-1:0]             prev_back_idx;
	deq_mode_t                 op;

	logic [AW-1:0]             head_d;
	logic [CW-1:0]             count_d;
	logic signed [DATA_W-1:0]  front_d;
	logic signed [DATA_W-1:0]  back_d;
	logic                      skip_d;
	logic                      rd_front_d;
	logic                      rd_back_d;

	assign accept = start && !valid_s1;
	assign busy   = valid_s1;
	assign op     = deq_mode_t'(mode);

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign many  = (count_q >= CW'(2));

	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign back_sum = SW'(head_q) + SW'(count_q) - SW'(2);
	assign tail_idx = AW'((tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum);
	assign prev_back_idx = AW'((back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum);

	always_comb begin
		head_d     = head_q;
		count_d    = count_q;
		front_d    = front_q;
		back_d     = back_q;
		skip_d     = 1'b0;
		rd_front_d = 1'b0;
		rd_back_d  = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = head_dec;
		ram_re     = 1'b0;
		ram_raddr  = head_inc;
		case (op)
			MODE_PUSH_FRONT: begin
				if (full) begin
					skip_d = 1'b1;
				end else begin
					head_d    = head_dec;
					count_d   = count_q + CW'(1);
					front_d   = value;
					ram_we    = accept;
					ram_waddr = head_dec;
					if (empty) begin
						back_d = value;
					end
				end
			end
			MODE_PUSH_BACK: begin
				if (full) begin
					skip_d = 1'b1;
				end else begin
					count_d   = count_q + CW'(1);
					back_d    = value;
					ram_we    = accept;
					ram_waddr = tail_idx;
					if (empty) begin
						front_d = value;
					end
				end
			end
			MODE_POP_FRONT: begin
				if (empty) begin
					skip_d = 1'b1;
				end else begin
					head_d     = head_inc;
					count_d    = count_q - CW'(1);
					rd_front_d = many;
					ram_re     = accept && many;
					ram_raddr  = head_inc;
				end
			end
			MODE_POP_BACK: begin
				if (empty) begin
					skip_d = 1'b1;
				end else begin
					count_d   = count_q - CW'(1);
					rd_back_d = many;
					ram_re    = accept && many;
					ram_raddr = prev_back_idx;
				end
			end
			default: begin
				skip_d = 1'b1;
			end
		endcase
	end

	assign ram_wdata = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			rd_front_s1 <= 1'b0;
			rd_back_s1  <= 1'b0;
			ignored_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				head_q      <= head_d;
				count_q     <= count_d;
				rd_front_s1 <= rd_front_d;
				rd_back_s1  <= rd_back_d;
				ignored_s1  <= skip_d;
			end
		end
	end

	// hold the end values; pick up the new end from the ring after a pop
	always_ff @(posedge clk) begin
		if (accept) begin
			front_q <= front_d;
			back_q  <= back_d;
		end else if (valid_s1) begin
			if (rd_front_s1) begin
				front_q <= ram_rdata;
			end
			if (rd_back_s1) begin
				back_q <= ram_rdata;
			end
		end
	end

	assign done        = valid_s1;
	assign front_value = empty ? '0 : (rd_front_s1 ? ram_rdata : front_q);
	assign back_value  = empty ? '0 : (rd_back_s1 ? ram_rdata : back_q);
	assign entry_count = COUNT_W'(count_q);

	always_comb begin
		flags          = '0;
		flags.is_empty = empty;
		flags.is_full  = full;
		flags.ignored  = ignored_s1;
	end

endmodule

// ----- design/double_ended_queue_unit.sv -----
// Top level of the double-ended queue of signed 32-bit values
`timescale 1ns / 1ps

// Double-ended queue held in a ring of DEPTH entries.
// Command channel: a beat (mode, value) is taken at a rising edge with start
// high and busy low. mode selects push front, push back, pop front or pop back;
// value is used by pushes only.
// Result channel: done is high for exactly one cycle, the cycle that follows
// the edge that takes the command.
// front_value, back_value, entry_count, is_empty, is_full and ignored are
// valid while done is high; the receiver cannot hold them off.
// The result comes in the cycle after the command edge. No new command is
// taken while the result is out: busy is high during the result cycle of
// every command, which covers the registered read of the ring memory that
// fetches the new end value after a pop.
// A push on a full queue or a pop on an empty queue changes nothing and sets
// ignored. End values read as 0 while the queue is empty.
// Reset (arst_n low) empties the queue at once; ring contents are left as is.

module double_ended_queue_unit #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        mode,
	input  logic signed [deq_pkg::DATA_W-1:0]  value,
	output logic                              done,
	output logic signed [deq_pkg::DATA_W-1:0]  front_value,
	output logic signed [deq_pkg::DATA_W-1:0]  back_value,
	output logic [deq_pkg::COUNT_W-1:0]       entry_count,
	output logic                              is_empty,
	output logic                              is_full,
	output logic                              ignored
);

	import deq_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	deq_flags_t          flags;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [DATA_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [DATA_W-1:0]   ram_rdata;

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.value      (value),
		.done       (done),
		.front_value(front_value),
		.back_value (back_value),
		.entry_count(entry_count),
		.flags      (flags),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	deq_ram #(
		.DEPTH(DEPTH),
		.WIDTH(DATA_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign is_empty = flags.is_empty;
	assign is_full  = flags.is_full;
	assign ignored  = flags.ignored;

	`ASSERT_CLK(a_result_follows_cmd, (start && !busy) |=> done, "no result after command")
	`ASSERT_CLK(a_single_result, done |=> !done, "result repeated")
	`ASSERT_NEVER(a_empty_values, done && is_empty && (front_value != '0 || back_value != '0),
		"nonzero end value on empty queue")
	`ASSERT_NEVER(a_ram_port_clash, ram_we && ram_re, "ring read and write in one cycle")

endmodule
